// ===== design/hrp_pkg.sv =====
// Shared types, constants and byte helpers for the HTTP request head parser.
// No dependencies; imported by the core, result queue, checker and top-level parser.
package hrp_pkg;

    localparam int SHORT_PART_MAX_DEF = 16;
    localparam int URI_PART_MAX_DEF   = 256;
    localparam int OUT_FIFO_DEPTH     = 4;

    typedef enum logic [1:0] {
        KIND_METHOD  = 2'd0,
        KIND_URI     = 2'd1,
        KIND_VERSION = 2'd2,
        KIND_SUMMARY = 2'd3
    } t_part_kind;

    typedef struct packed {
        t_part_kind  kind;
        logic [7:0]  data;
        logic        keep;
        logic        last;
    } t_result;

    // Up to two results per input word, always packed from slot 0.
    typedef struct packed {
        logic    v0;
        t_result r0;
        logic    v1;
        t_result r1;
    } t_push;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [3:0] VER_LEN   = 4'd8;
    localparam logic [3:0] CONN_LEN  = 4'd11;
    localparam logic [3:0] KEEP_LEN  = 4'd10;
    localparam logic [2:0] CLOSE_LEN = 3'd5;

    localparam logic [7:0] VER_PAT [8] = '{"H", "T", "T", "P", "/", "1", ".", "1"};
    localparam logic [7:0] CONN_PAT [11] =
        '{"C", "O", "N", "N", "E", "C", "T", "I", "O", "N", ":"};
    localparam logic [7:0] KEEP_PAT [10] =
        '{"K", "E", "E", "P", "-", "A", "L", "I", "V", "E"};
    localparam logic [7:0] CLOSE_PAT [5] = '{"C", "L", "O", "S", "E"};

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "a" && c <= "z") begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    // Substring matchers. Only the first letter of each pattern recurs, except in
    // CONNECTION: where "CONNEC" ends in "C", so a following "O" falls back to two.
    function automatic logic [3:0] conn_step(input logic [3:0] k, input logic [7:0] c);
        logic [3:0] r;
        if (k >= CONN_LEN) begin
            r = CONN_LEN;
        end else if (c == CONN_PAT[k]) begin
            r = k + 4'd1;
        end else if (k == 4'd6 && c == CONN_PAT[1]) begin
            r = 4'd2;
        end else if (c == CONN_PAT[0]) begin
            r = 4'd1;
        end else begin
            r = 4'd0;
        end
        return r;
    endfunction

    function automatic logic [3:0] keep_step(input logic [3:0] k, input logic [7:0] c);
        logic [3:0] r;
        if (k >= KEEP_LEN) begin
            r = KEEP_LEN;
        end else if (c == KEEP_PAT[k]) begin
            r = k + 4'd1;
        end else if (c == KEEP_PAT[0]) begin
            r = 4'd1;
        end else begin
            r = 4'd0;
        end
        return r;
    endfunction

    function automatic logic [2:0] close_step(input logic [2:0] k, input logic [7:0] c);
        logic [2:0] r;
        if (k >= CLOSE_LEN) begin
            r = CLOSE_LEN;
        end else if (c == CLOSE_PAT[k]) begin
            r = k + 3'd1;
        end else if (c == CLOSE_PAT[0]) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    // Keep-alive after a header line closes; flags are CONNECTION:, KEEP-ALIVE, CLOSE.
    function automatic logic keep_after_line(input logic [2:0] flags, input logic kf);
        logic r;
        r = kf;
        if (flags[0]) begin
            if (flags[1]) begin
                r = 1'b1;
            end else if (flags[2]) begin
                r = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

// ===== design/hrp_if.sv =====
// Valid/ready channel interfaces for the request byte input and the result output.
// Depends on nothing; field widths follow the parser's item formats.
interface hrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] req_byte;
    logic       end_of_head;

    modport source (output valid, output req_byte, output end_of_head, input ready);
    modport sink   (input valid, input req_byte, input end_of_head, output ready);
endinterface

interface hrp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] part_kind;
    logic [7:0] part_byte;
    logic       keep_open;
    logic       run_last;

    modport source (output valid, output part_kind, output part_byte,
                    output keep_open, output run_last, input ready);
    modport sink   (input valid, input part_kind, input part_byte,
                    input keep_open, input run_last, output ready);
endinterface

// ===== design/http_request_head_parser.sv =====
// HTTP request head parser, one request byte per word.
// An accepted byte is held in an input register; its results then go into the result queue.
// Throughput: one byte per cycle while the queue has room; a final byte that emits
// a part byte gives two results, drained one per ready cycle by a four-entry queue.
// Reset (synchronous, active low) empties the pipeline and returns to the request line.
module http_request_head_parser
    import hrp_pkg::*;
#(
    parameter int SHORT_PART_MAX = SHORT_PART_MAX_DEF,
    parameter int URI_PART_MAX   = URI_PART_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrp_in_if.sink    i_req,
    hrp_out_if.source o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       room;
    logic       step;
    logic       accept;
    t_push      push;

    assign step        = r_in_valid && room;
    assign i_req.ready = !r_in_valid || room;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_req.req_byte;
            r_in_last <= i_req.end_of_head;
        end
    end

    hrp_core #(
        .SHORT_PART_MAX (SHORT_PART_MAX),
        .URI_PART_MAX   (URI_PART_MAX)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_push  (push)
    );

    hrp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

// ===== design/hrp_core.sv =====
// Parser state machine: phase tracking, part splitting and keep-alive matching.
// Depends on hrp_pkg; produces up to two results for each stepped word.
module hrp_core
    import hrp_pkg::*;
#(
    parameter int SHORT_PART_MAX = SHORT_PART_MAX_DEF,
    parameter int URI_PART_MAX   = URI_PART_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_push      o_push
);

    localparam int PART_MAX = (SHORT_PART_MAX > URI_PART_MAX) ? SHORT_PART_MAX : URI_PART_MAX;
    localparam int CNT_W    = $clog2(PART_MAX + 1);
    localparam logic [CNT_W-1:0] SHORT_LIM = CNT_W'(SHORT_PART_MAX);
    localparam logic [CNT_W-1:0] URI_LIM   = CNT_W'(URI_PART_MAX);
    localparam logic [CNT_W-1:0] VER_CHK   = CNT_W'(VER_LEN);

    typedef enum logic [2:0] {
        PH_PRE, PH_METHOD, PH_URI, PH_VERSION, PH_VERDONE, PH_HEADERS, PH_STOPPED
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_pc, n_pc;
    logic [3:0]       r_vp, n_vp;
    logic             r_vf, n_vf;
    logic             r_kf, n_kf;
    logic [3:0]       r_cp, n_cp;
    logic [3:0]       r_kp, n_kp;
    logic [2:0]       r_clp, n_clp;
    logic [2:0]       r_ff, n_ff;

    logic             emit;
    t_part_kind       kind;
    logic [7:0]       ob;
    logic [7:0]       u;
    logic [CNT_W-1:0] lim;
    t_result          byte_res;
    t_result          sum_res;

    assign u = upcase(i_byte);

    always_comb begin
        n_phase = r_phase;
        n_pc    = r_pc;
        n_vp    = r_vp;
        n_vf    = r_vf;
        n_kf    = r_kf;
        n_cp    = r_cp;
        n_kp    = r_kp;
        n_clp   = r_clp;
        n_ff    = r_ff;
        emit    = 1'b0;
        kind    = KIND_METHOD;
        ob      = 8'h00;
        lim     = SHORT_LIM;
        sum_res = '{kind: KIND_SUMMARY, data: 8'h00, keep: 1'b0, last: 1'b1};

        if (i_step) begin
            if (n_phase == PH_PRE) begin
                if (i_byte != CH_LF && i_byte != CH_NUL) begin
                    n_phase = PH_METHOD;
                    n_pc    = '0;
                    n_vp    = '0;
                    n_vf    = 1'b0;
                end else if (i_byte == CH_NUL) begin
                    n_phase = PH_STOPPED;
                end
            end

            unique case (n_phase) inside
                PH_METHOD, PH_URI, PH_VERSION, PH_VERDONE: begin
                    if (i_byte == CH_LF || i_byte == CH_NUL) begin
                        // A zero byte ends the text as a terminator would.
                        n_kf    = (n_vp == VER_LEN) && !n_vf;
                        n_phase = (i_byte == CH_NUL) ? PH_STOPPED : PH_HEADERS;
                        n_cp    = '0;
                        n_kp    = '0;
                        n_clp   = '0;
                        n_ff    = '0;
                    end else if (n_phase == PH_METHOD || n_phase == PH_URI) begin
                        lim = (n_phase == PH_METHOD) ? SHORT_LIM : URI_LIM;
                        if (i_byte == CH_SP) begin
                            n_phase = (n_phase == PH_METHOD) ? PH_URI : PH_VERSION;
                            n_pc    = '0;
                        end else if (n_pc < lim) begin
                            emit = 1'b1;
                            kind = (n_phase == PH_METHOD) ? KIND_METHOD : KIND_URI;
                            ob   = (n_phase == PH_METHOD) ? u : i_byte;
                            n_pc = n_pc + CNT_W'(1);
                        end
                    end else if (n_phase == PH_VERSION) begin
                        if (i_byte == CH_CR) begin
                            n_phase = PH_VERDONE;
                        end else if (n_pc < SHORT_LIM) begin
                            emit = 1'b1;
                            kind = KIND_VERSION;
                            ob   = u;
                            if (n_pc < VER_CHK && !n_vf) begin
                                if (u == VER_PAT[n_pc[2:0]]) begin
                                    n_vp = n_vp + 4'd1;
                                end else begin
                                    n_vf = 1'b1;
                                end
                            end
                            n_pc = n_pc + CNT_W'(1);
                        end
                    end
                end
                PH_HEADERS: begin
                    if (i_byte == CH_LF || i_byte == CH_NUL) begin
                        n_kf  = keep_after_line(n_ff, n_kf);
                        n_cp  = '0;
                        n_kp  = '0;
                        n_clp = '0;
                        n_ff  = '0;
                        if (i_byte == CH_NUL) begin
                            n_phase = PH_STOPPED;
                        end
                    end else begin
                        n_cp  = conn_step(n_cp, u);
                        n_kp  = keep_step(n_kp, u);
                        n_clp = close_step(n_clp, u);
                        n_ff  = n_ff | {n_clp == CLOSE_LEN, n_kp == KEEP_LEN,
                                        n_cp == CONN_LEN};
                    end
                end
                default: begin
                end
            endcase

            if (i_last) begin
                // Close whatever line is open, report, then start over for the next head.
                if (n_phase inside {PH_METHOD, PH_URI, PH_VERSION, PH_VERDONE}) begin
                    sum_res.keep = (n_vp == VER_LEN) && !n_vf;
                end else if (n_phase == PH_HEADERS) begin
                    sum_res.keep = keep_after_line(n_ff, n_kf);
                end else begin
                    sum_res.keep = n_kf;
                end
                n_phase = PH_PRE;
                n_pc    = '0;
                n_vp    = '0;
                n_vf    = 1'b0;
                n_kf    = 1'b0;
                n_cp    = '0;
                n_kp    = '0;
                n_clp   = '0;
                n_ff    = '0;
            end
        end
    end

    assign byte_res = '{kind: kind, data: ob, keep: 1'b0, last: !i_last};

    always_comb begin
        o_push.v0 = i_step && (emit || i_last);
        o_push.r0 = emit ? byte_res : sum_res;
        o_push.v1 = i_step && emit && i_last;
        o_push.r1 = sum_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PRE;
            r_pc    <= '0;
            r_vp    <= '0;
            r_vf    <= 1'b0;
            r_kf    <= 1'b0;
            r_cp    <= '0;
            r_kp    <= '0;
            r_clp   <= '0;
            r_ff    <= '0;
        end else begin
            r_phase <= n_phase;
            r_pc    <= n_pc;
            r_vp    <= n_vp;
            r_vf    <= n_vf;
            r_kf    <= n_kf;
            r_cp    <= n_cp;
            r_kp    <= n_kp;
            r_clp   <= n_clp;
            r_ff    <= n_ff;
        end
    end

endmodule

// ===== design/hrp_out_fifo.sv =====
// Small result queue: takes up to two results per cycle, hands out one per word.
// Depends on hrp_pkg and hrp_out_if.
module hrp_out_fifo
    import hrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output logic       o_room,
    hrp_out_if.source  o_res
);

    localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);
    localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

    t_result          r_mem [OUT_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       push_num;
    logic             pop;
    t_result          head;

    assign push_num = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign pop      = o_res.valid && o_res.ready;
    // Room for a full pair; the writer only pushes while this is high.
    assign o_room   = r_count <= CNT_W'(OUT_FIFO_DEPTH - 2);

    assign n_wr_ptr = r_wr_ptr + PTR_W'(push_num);
    assign n_rd_ptr = r_rd_ptr + PTR_W'(pop);
    assign n_count  = r_count + CNT_W'(push_num) - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign head             = r_mem[r_rd_ptr];
    assign o_res.valid      = r_count != '0;
    assign o_res.part_kind  = head.kind;
    assign o_res.part_byte  = head.data;
    assign o_res.keep_open  = head.keep;
    assign o_res.run_last   = head.last;

endmodule

// ===== design/hrp_checker.sv =====
// Port-level checks for the HTTP request head parser, bound to the top level.
// Depends on hrp_pkg for the result kind codes.
module hrp_checker
    import hrp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_part_kind,
    input logic [7:0] i_part_byte,
    input logic       i_keep_open,
    input logic       i_run_last
);

    // Reset empties the result queue.
    assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A summary closes the head: it is last, and it carries no byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_part_kind == KIND_SUMMARY |-> i_run_last && i_part_byte == 8'h00)
        else $error("malformed summary word");

    // Keep-alive is only reported in a summary.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_part_kind != KIND_SUMMARY |-> !i_keep_open)
        else $error("keep-alive set on a part byte");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_part_kind)
            && $stable(i_part_byte) && $stable(i_keep_open) && $stable(i_run_last))
        else $error("stalled result word changed");

endmodule

bind http_request_head_parser hrp_checker u_hrp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_part_kind  (o_res.part_kind),
    .i_part_byte  (o_res.part_byte),
    .i_keep_open  (o_res.keep_open),
    .i_run_last   (o_res.run_last)
);

// ===== verif/tb_http_request_head_parser.sv =====
// Self-checking testbench for http_request_head_parser: request heads go in one byte per word,
// and a built-in parser model predicts every part byte and keep-alive summary that comes back.
// Depends on hrp_pkg (types and byte constants) and hrp_if (channel interfaces).
`timescale 1ns / 100ps

module tb_http_request_head_parser;
    import hrp_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int END_WAIT_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int HOLD_OFF_LEN   = 60;
    localparam int MAX_PRINTED    = 40;

    // Patterns are right-aligned in the vector so that shorter words zero-extend on the left.
    localparam logic [87:0] WORD_VERSION = "HTTP/1.1";
    localparam logic [87:0] WORD_CONN    = "CONNECTION:";
    localparam logic [87:0] WORD_KEEP    = "KEEP-ALIVE";
    localparam logic [87:0] WORD_CLOSE   = "CLOSE";

    typedef enum logic [2:0] {
        PS_PRE,
        PS_METHOD,
        PS_URI,
        PS_VERSION,
        PS_VER_DONE,
        PS_HEADERS,
        PS_STOPPED
    } t_parse_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrp_in_if  req_if ();
    hrp_out_if res_if ();

    http_request_head_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Parser model state.
    t_parse_phase parse_phase;
    int           part_len;
    int           ver_matched;
    bit           ver_mismatch;
    bit           keep_open_now;
    int           conn_hits;
    int           keep_hits;
    int           close_hits;
    logic [2:0]   line_flags;

    t_result      expected_results[$];
    logic [7:0]   head_bytes[$];

    bit src_gaps  = 1'b1;
    bit sink_gaps = 1'b1;
    int hold_request = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int heads_sent     = 0;
    int results_seen   = 0;
    int keep_summaries = 0;
    int summaries_seen = 0;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        if (c >= "a" && c <= "z") begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] pat_char(input logic [87:0] pat, input int len, input int i);
        return pat[8*(len-1-i) +: 8];
    endfunction

    // Length of the longest pattern prefix that ends the text after k matched bytes and c.
    function automatic int next_match(input logic [87:0] pat, input int len, input int k,
                                      input logic [7:0] c);
        int j;
        int i;
        bit ok;
        if (k >= len) begin
            return len;
        end
        for (j = k + 1; j > 0; j--) begin
            if (pat_char(pat, len, j - 1) == c) begin
                ok = 1'b1;
                for (i = 0; i < j - 1; i++) begin
                    if (pat_char(pat, len, i) != pat_char(pat, len, k - (j - 1) + i)) begin
                        ok = 1'b0;
                    end
                end
                if (ok) begin
                    return j;
                end
            end
        end
        return 0;
    endfunction

    function automatic void clear_line_match();
        conn_hits  = 0;
        keep_hits  = 0;
        close_hits = 0;
        line_flags = 3'b000;
    endfunction

    function automatic void restart_parser();
        parse_phase    = PS_PRE;
        part_len       = 0;
        ver_matched    = 0;
        ver_mismatch   = 1'b0;
        keep_open_now  = 1'b0;
        clear_line_match();
    endfunction

    function automatic void finish_request_line();
        keep_open_now = (ver_matched == 8) && !ver_mismatch;
        parse_phase   = PS_HEADERS;
        clear_line_match();
    endfunction

    function automatic void finish_header_line();
        if (line_flags[0]) begin
            if (line_flags[1]) begin
                keep_open_now = 1'b1;
            end else if (line_flags[2]) begin
                keep_open_now = 1'b0;
            end
        end
        clear_line_match();
    endfunction

    // Advances the model by one accepted byte and queues the results it causes.
    function automatic void predict_results(input logic [7:0] c, input logic last);
        logic [7:0] u;
        bit         emit;
        t_part_kind kind;
        logic [7:0] ob;
        int         lim;
        u    = fold_upper(c);
        emit = 1'b0;
        kind = KIND_METHOD;
        ob   = 8'h00;

        if (parse_phase == PS_PRE && c != CH_LF && c != CH_NUL) begin
            parse_phase  = PS_METHOD;
            part_len     = 0;
            ver_matched  = 0;
            ver_mismatch = 1'b0;
        end else if (parse_phase == PS_PRE && c == CH_NUL) begin
            parse_phase = PS_STOPPED;
        end

        case (parse_phase)
            PS_METHOD, PS_URI, PS_VERSION, PS_VER_DONE: begin
                if (c == CH_LF) begin
                    finish_request_line();
                end else if (c == CH_NUL) begin
                    finish_request_line();
                    parse_phase = PS_STOPPED;
                end else if (parse_phase == PS_METHOD || parse_phase == PS_URI) begin
                    lim = (parse_phase == PS_METHOD) ? SHORT_PART_MAX_DEF : URI_PART_MAX_DEF;
                    if (c == CH_SP) begin
                        parse_phase = (parse_phase == PS_METHOD) ? PS_URI : PS_VERSION;
                        part_len    = 0;
                    end else if (part_len < lim) begin
                        emit = 1'b1;
                        kind = (parse_phase == PS_METHOD) ? KIND_METHOD : KIND_URI;
                        ob   = (parse_phase == PS_METHOD) ? u : c;
                        part_len++;
                    end
                end else if (parse_phase == PS_VERSION) begin
                    if (c == CH_CR) begin
                        parse_phase = PS_VER_DONE;
                    end else if (part_len < SHORT_PART_MAX_DEF) begin
                        emit = 1'b1;
                        kind = KIND_VERSION;
                        ob   = u;
                        if (part_len < 8 && !ver_mismatch) begin
                            if (u == pat_char(WORD_VERSION, 8, part_len)) begin
                                ver_matched++;
                            end else begin
                                ver_mismatch = 1'b1;
                            end
                        end
                        part_len++;
                    end
                end
            end
            PS_HEADERS: begin
                if (c == CH_LF) begin
                    finish_header_line();
                end else if (c == CH_NUL) begin
                    finish_header_line();
                    parse_phase = PS_STOPPED;
                end else begin
                    conn_hits  = next_match(WORD_CONN, 11, conn_hits, u);
                    keep_hits  = next_match(WORD_KEEP, 10, keep_hits, u);
                    close_hits = next_match(WORD_CLOSE, 5, close_hits, u);
                    if (conn_hits == 11) line_flags[0] = 1'b1;
                    if (keep_hits == 10) line_flags[1] = 1'b1;
                    if (close_hits == 5) line_flags[2] = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (emit) begin
            expected_results.push_back('{kind: kind, data: ob, keep: 1'b0, last: !last});
        end
        if (last) begin
            if (parse_phase >= PS_METHOD && parse_phase <= PS_VER_DONE) begin
                finish_request_line();
            end else if (parse_phase == PS_HEADERS) begin
                finish_header_line();
            end
            expected_results.push_back('{kind: KIND_SUMMARY, data: 8'h00,
                                         keep: keep_open_now, last: 1'b1});
            restart_parser();
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    // Sends one word and waits for it to be taken. Callers stand at a rising edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (src_gaps && $urandom_range(99) < 33) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_byte    <= b;
        req_if.end_of_head <= last;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_results(b, last);
        bytes_sent++;
    endtask

    task automatic send_head();
        int i;
        if (head_bytes.size() == 0) begin
            head_bytes.push_back(CH_LF);
        end
        for (i = 0; i < head_bytes.size(); i++) begin
            send_byte(head_bytes[i], i == head_bytes.size() - 1);
        end
        heads_sent++;
        head_bytes.delete();
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic append_text(input string s, input bit mix_case);
        int i;
        logic [7:0] c;
        for (i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && (c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(1)) begin
                c = c ^ 8'h20;
            end
            head_bytes.push_back(c);
        end
    endtask

    // A letter most of the time without any_byte; else any byte but space, newline and zero.
    function automatic logic [7:0] rand_text_byte(input bit any_byte);
        logic [7:0] c;
        if (!any_byte && $urandom_range(7) != 0) begin
            c = 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h61 : 8'h41);
        end else begin
            do begin
                c = 8'($urandom_range(1, 255));
            end while (c == CH_SP || c == CH_LF);
        end
        return c;
    endfunction

    task automatic push_random_run(input int n, input bit any_byte);
        repeat (n) head_bytes.push_back(rand_text_byte(any_byte));
    endtask

    task automatic build_random_head();
        int n;
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) head_bytes.push_back(CH_LF);
        end
        // Noise: a short run of arbitrary bytes with no structure.
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 10)) head_bytes.push_back(8'($urandom_range(255)));
            return;
        end

        n = ($urandom_range(19) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 5);
        push_random_run(n, 1'b0);
        if ($urandom_range(19) != 0) head_bytes.push_back(CH_SP);
        if ($urandom_range(7) != 0) head_bytes.push_back("/");
        push_random_run($urandom_range(0, 5), $urandom_range(3) == 0);
        if ($urandom_range(19) != 0) head_bytes.push_back(CH_SP);

        case ($urandom_range(9))
            6:       append_text("HTTP/1.0", 1'b1);
            7: begin
                append_text("HTTP/1.1 ", 1'b1);
                push_random_run($urandom_range(1, 9), 1'b0);
            end
            8:       append_text("HTTP/1", 1'b1);
            9:       push_random_run($urandom_range(1, 20), 1'b1);
            default: append_text("HTTP/1.1", 1'b1);
        endcase
        if ($urandom_range(4) != 0) begin
            head_bytes.push_back(CH_CR);
            // Anything after the carriage return on the request line is dropped.
            if ($urandom_range(4) == 0) push_random_run($urandom_range(1, 3), 1'b1);
        end
        head_bytes.push_back(CH_LF);

        repeat ($urandom_range(3)) begin
            case ($urandom_range(7))
                0: append_text("Connection: keep-alive", 1'b1);
                1: append_text("Connection: close", 1'b1);
                2: append_text("connection:close,Keep-Alive", 1'b1);
                3: append_text("Host: a", 1'b1);
                4: append_text("Keep-Alive: 9", 1'b1);
                5: append_text("ConneConnection:CLOSE", 1'b1);
                6: append_text("Connection:keep-keep-alive", 1'b1);
                default: push_random_run($urandom_range(1, 6), 1'b1);
            endcase
            if ($urandom_range(3) != 0) head_bytes.push_back(CH_CR);
            head_bytes.push_back(CH_LF);
        end

        case ($urandom_range(9))
            0: begin
                head_bytes.push_back(CH_NUL);
                repeat ($urandom_range(1, 3)) head_bytes.push_back(8'($urandom_range(255)));
            end
            1: begin
                n = $urandom_range(1, head_bytes.size());
                while (head_bytes.size() > n) void'(head_bytes.pop_back());
            end
            2: head_bytes.push_back(CH_LF);
            default: begin
            end
        endcase
    endtask

    task automatic test_directed_cases();
        head_bytes.push_back(CH_LF);
        send_head();
        head_bytes.push_back(CH_NUL);
        head_bytes.push_back(8'hFF);
        send_head();
        append_text("a b", 1'b0);
        send_head();
        append_text("M / HTTP/1.1", 1'b0);
        send_head();
        append_text("A B C D", 1'b0);
        send_head();
        append_text("x", 1'b0);
        head_bytes.push_back(CH_CR);
        append_text("Y", 1'b0);
        send_head();
    endtask

    // Method, URI and version each run past their buffer size.
    task automatic test_long_parts();
        push_random_run(SHORT_PART_MAX_DEF + 2, 1'b0);
        head_bytes.push_back(CH_SP);
        head_bytes.push_back("/");
        push_random_run(URI_PART_MAX_DEF + 1, 1'b0);
        head_bytes.push_back(CH_SP);
        append_text("http/1.1", 1'b0);
        push_random_run(SHORT_PART_MAX_DEF - 6, 1'b0);
        head_bytes.push_back(CH_CR);
        head_bytes.push_back(CH_LF);
        append_text("Connection: close", 1'b1);
        head_bytes.push_back(CH_LF);
        send_head();
    endtask

    task automatic test_random_heads();
        while (bytes_sent < 470) begin
            src_gaps  = !(bytes_sent >= 370 && bytes_sent < 450);
            sink_gaps = src_gaps;
            build_random_head();
            send_head();
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // The result side holds off while the input side keeps offering words back to back.
    task automatic test_result_backpressure();
        hold_request = HOLD_OFF_LEN;
        src_gaps     = 1'b0;
        append_text("get /index HTTP/1.1", 1'b0);
        head_bytes.push_back(CH_CR);
        head_bytes.push_back(CH_LF);
        send_head();
        build_random_head();
        send_head();
        src_gaps = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (2) begin
            wait_drained();
            build_random_head();
            send_head();
        end
    endtask

    always @(posedge i_clk) begin : drive_result_ready
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else if (sink_gaps) begin
            res_if.ready <= ($urandom_range(99) >= 33);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.kind = t_part_kind'(res_if.part_kind);
            got.data = res_if.part_byte;
            got.keep = res_if.keep_open;
            got.last = res_if.run_last;
            results_seen++;
            if (got.kind == KIND_SUMMARY) begin
                summaries_seen++;
                if (got.keep) keep_summaries++;
            end
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d byte %02h keep %0b last %0b",
                                          got.kind, got.data, got.keep, got.last));
            end else begin
                want = expected_results.pop_front();
                if (got.kind != want.kind)
                    report_mismatch($sformatf("part_kind %0d, expected %0d", got.kind, want.kind));
                if (got.data != want.data)
                    report_mismatch($sformatf("part_byte %02h, expected %02h", got.data, want.data));
                if (got.keep != want.keep)
                    report_mismatch($sformatf("keep_open %0b, expected %0b", got.keep, want.keep));
                if (got.last != want.last)
                    report_mismatch($sformatf("run_last %0b, expected %0b", got.last, want.last));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no word accepted for %0d cycles", $time, quiet_cycles);
            $display("tb_http_request_head_parser: done, errors");
            $finish;
        end
    end

    initial begin : run_tests
        int guard;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_byte    = 8'h00;
        req_if.end_of_head = 1'b0;
        restart_parser();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_long_parts();
        test_random_heads();
        test_result_backpressure();
        test_drain_pause();

        req_if.valid <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < END_WAIT_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        end

        $display("Covered %0d request heads in %0d bytes; %0d results checked.",
                 heads_sent, bytes_sent, results_seen);
        $display("%0d summaries, %0d with keep-alive set; %0d mismatches.",
                 summaries_seen, keep_summaries, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_http_request_head_parser: done, clean");
        end else begin
            $display("tb_http_request_head_parser: done, errors");
        end
        $finish;
    end

endmodule
